FILE: design/ple_pkg.sv
`default_nettype none
package ple_pkg;

  // list capacity and derived widths
  localparam int DEPTH = 16;
  localparam int DATA_W = 32;
  localparam int POS_W = 7;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // command codes
  localparam logic [2:0] FUNC_INS_FRONT = 3'd0;
  localparam logic [2:0] FUNC_INS_POS   = 3'd1;
  localparam logic [2:0] FUNC_INS_END   = 3'd2;
  localparam logic [2:0] FUNC_DEL_FRONT = 3'd3;
  localparam logic [2:0] FUNC_DEL_POS   = 3'd4;
  localparam logic [2:0] FUNC_DEL_END   = 3'd5;
  localparam logic [2:0] FUNC_DISPLAY   = 3'd6;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [2:0]              func;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]        position;
  } ple_in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [DATA_W-1:0] element;
    logic                    element_valid;
    logic                    last;
  } ple_out_t;

  // action broadcast along the chain
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_DEL,
    OP_ROT
  } ple_op_t;

  typedef struct packed {
    ple_op_t           op;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  last_idx;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] wrap;
  } ple_cmd_t;

endpackage
`default_nettype wire

FILE: design/positional_list_engine.sv
`default_nettype none
// positional list engine: ordered list of up to DEPTH signed 32-bit values
// in_data carries one command per transfer (insert front/position/end,
// delete front/position/end, display); out_data carries the results.
// both channels are valid/ready; results sit in an output register.
// insert and delete: one status result with last set, visible the cycle
// after the command transfer. the affected cells shift together in that
// cycle, so a new command may follow as soon as the output register frees.
// display: the chain rotates towards the front once per result, the front
// cell giving each element; the n stored elements come out front to back,
// the final one with last set. after n rotations the list is back in
// order. an empty display gives one status.
// command code 7 is dropped with no result.
// in_ready is low while a display is streaming.
// a stalled receiver holds the output register and freezes the rotation;
// no command is taken until the held result is transferred.
// reset empties the list at once (entry count to zero); cell contents are
// left as they are and never read before being written.
module positional_list_engine (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ple_pkg::ple_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ple_pkg::ple_out_t      out_data
);

  typedef enum logic {S_IDLE, S_DISP} state_t;

  state_t                     state, state_next;
  logic [ple_pkg::CNT_W-1:0]  count, count_next;
  logic [ple_pkg::CNT_W-1:0]  remain, remain_next;
  logic                       out_valid_next;
  ple_pkg::ple_out_t          out_data_next;
  ple_pkg::ple_cmd_t          cmd;
  logic [ple_pkg::DATA_W-1:0] cell_val [ple_pkg::DEPTH];
  logic                       out_free;
  logic                       in_take;
  logic [ple_pkg::CMP_W-1:0]  pos_w, cnt_w;
  logic                       full;
  logic [ple_pkg::IDX_W-1:0]  pos_idx, cnt_idx, last_idx;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign in_take  = in_valid && in_ready;

  assign pos_w    = ple_pkg::CMP_W'(in_data.position);
  assign cnt_w    = ple_pkg::CMP_W'(count);
  assign full     = (count == ple_pkg::CNT_W'(ple_pkg::DEPTH));
  assign pos_idx  = ple_pkg::IDX_W'(in_data.position - ple_pkg::POS_W'(1));
  assign cnt_idx  = count[ple_pkg::IDX_W-1:0];
  assign last_idx = ple_pkg::IDX_W'(count - ple_pkg::CNT_W'(1));

  // command decode, status and chain action
  always_comb begin
    state_next     = state;
    count_next     = count;
    remain_next    = remain;
    out_valid_next = out_valid && !out_ready;
    out_data_next  = out_data;
    cmd.op         = ple_pkg::OP_HOLD;
    cmd.idx        = '0;
    cmd.last_idx   = last_idx;
    cmd.value      = in_data.value;
    cmd.wrap       = cell_val[0];

    if (in_take) begin
      out_data_next.status        = ple_pkg::ST_OK;
      out_data_next.element       = '0;
      out_data_next.element_valid = 1'b0;
      out_data_next.last          = 1'b1;
      out_valid_next              = 1'b1;
      case (in_data.func)
        ple_pkg::FUNC_INS_FRONT, ple_pkg::FUNC_INS_END: begin
          if (full) begin
            out_data_next.status = ple_pkg::ST_FULL;
          end else begin
            cmd.op     = ple_pkg::OP_INS;
            cmd.idx    = (in_data.func == ple_pkg::FUNC_INS_FRONT) ? '0 : cnt_idx;
            count_next = count + ple_pkg::CNT_W'(1);
          end
        end
        ple_pkg::FUNC_INS_POS: begin
          if (pos_w == '0 || pos_w > cnt_w + ple_pkg::CMP_W'(1)) begin
            out_data_next.status = ple_pkg::ST_RANGE;
          end else if (full) begin
            out_data_next.status = ple_pkg::ST_FULL;
          end else begin
            cmd.op     = ple_pkg::OP_INS;
            cmd.idx    = pos_idx;
            count_next = count + ple_pkg::CNT_W'(1);
          end
        end
        ple_pkg::FUNC_DEL_FRONT, ple_pkg::FUNC_DEL_END: begin
          if (count == '0) begin
            out_data_next.status = ple_pkg::ST_EMPTY;
          end else begin
            cmd.op     = ple_pkg::OP_DEL;
            cmd.idx    = (in_data.func == ple_pkg::FUNC_DEL_FRONT) ? '0 : last_idx;
            count_next = count - ple_pkg::CNT_W'(1);
          end
        end
        ple_pkg::FUNC_DEL_POS: begin
          if (count == '0) begin
            out_data_next.status = ple_pkg::ST_EMPTY;
          end else if (pos_w == '0 || pos_w > cnt_w) begin
            out_data_next.status = ple_pkg::ST_RANGE;
          end else begin
            cmd.op     = ple_pkg::OP_DEL;
            cmd.idx    = pos_idx;
            count_next = count - ple_pkg::CNT_W'(1);
          end
        end
        ple_pkg::FUNC_DISPLAY: begin
          if (count == '0) begin
            out_data_next.status = ple_pkg::ST_EMPTY;
          end else begin
            out_valid_next = 1'b0;
            remain_next    = count;
            state_next     = S_DISP;
          end
        end
        default: begin
          out_valid_next = 1'b0;
        end
      endcase
    end else if (state == S_DISP && out_free) begin
      // stream the front cell and rotate the list by one
      out_valid_next              = 1'b1;
      out_data_next.status        = ple_pkg::ST_OK;
      out_data_next.element       = cell_val[0];
      out_data_next.element_valid = 1'b1;
      out_data_next.last          = (remain == ple_pkg::CNT_W'(1));
      cmd.op                      = ple_pkg::OP_ROT;
      remain_next                 = remain - ple_pkg::CNT_W'(1);
      if (remain == ple_pkg::CNT_W'(1)) begin
        state_next = S_IDLE;
      end
    end
  end

  // control state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      remain    <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      remain    <= remain_next;
      out_valid <= out_valid_next;
    end
    out_data <= out_data_next;
  end

  // chain of list cells, front is cell 0
  for (genvar i = 0; i < ple_pkg::DEPTH; i++) begin : g_cell
    logic [ple_pkg::DATA_W-1:0] prev_v, next_v;
    if (i == 0) begin : g_front
      assign prev_v = cmd.value;
    end else begin : g_mid_p
      assign prev_v = cell_val[i-1];
    end
    if (i == ple_pkg::DEPTH - 1) begin : g_back
      assign next_v = cell_val[i];
    end else begin : g_mid_n
      assign next_v = cell_val[i+1];
    end
    ple_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .self_idx (ple_pkg::IDX_W'(i)),
      .prev_val (prev_v),
      .next_val (next_v),
      .val      (cell_val[i])
    );
  end

endmodule
`default_nettype wire

FILE: design/ple_cell.sv
`default_nettype none
module ple_cell (
  input  wire logic                       clk,
  input  wire ple_pkg::ple_cmd_t          cmd,
  input  wire logic [ple_pkg::IDX_W-1:0]  self_idx,
  input  wire logic [ple_pkg::DATA_W-1:0] prev_val,
  input  wire logic [ple_pkg::DATA_W-1:0] next_val,
  output logic      [ple_pkg::DATA_W-1:0] val
);

  // one list slot: load, take from the front neighbour or from the back one
  always_ff @(posedge clk) begin
    case (cmd.op)
      ple_pkg::OP_INS: begin
        if (self_idx == cmd.idx) begin
          val <= cmd.value;
        end else if (self_idx > cmd.idx) begin
          val <= prev_val;
        end
      end
      ple_pkg::OP_DEL: begin
        if (self_idx >= cmd.idx) begin
          val <= next_val;
        end
      end
      ple_pkg::OP_ROT: begin
        if (self_idx == cmd.last_idx) begin
          val <= cmd.wrap;
        end else if (self_idx < cmd.last_idx) begin
          val <= next_val;
        end
      end
      default: begin
        val <= val;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: test/tb.sv
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // command code with no function, dropped by the block
  localparam logic [2:0] FUNC_RESERVED = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int ITEMS_PER_PHASE = 87;
  localparam int BIAS_STRETCH = 40;

  // mirror of the list contents and the queue of results it predicts
  class list_scoreboard;
    logic signed [ple_pkg::DATA_W-1:0] cells [ple_pkg::DEPTH];
    int entries;
    ple_pkg::ple_out_t expected_results [$];
    int unsigned failures;

    function new();
      entries = 0;
      failures = 0;
    endfunction

    function void push_result(logic [1:0] st, logic signed [ple_pkg::DATA_W-1:0] elem,
                              logic shown, logic fin);
      ple_pkg::ple_out_t r;
      r.status = st;
      r.element = elem;
      r.element_valid = shown;
      r.last = fin;
      expected_results.push_back(r);
    endfunction

    // insert so the value becomes entry number pos (1-based)
    function logic [1:0] insert_value(int pos, logic signed [ple_pkg::DATA_W-1:0] v);
      if (pos < 1 || pos > entries + 1) return ple_pkg::ST_RANGE;
      if (entries >= ple_pkg::DEPTH) return ple_pkg::ST_FULL;
      for (int i = entries; i >= pos; i--) cells[i] = cells[i-1];
      cells[pos-1] = v;
      entries++;
      return ple_pkg::ST_OK;
    endfunction

    // remove entry number pos (1-based), later entries close the gap
    function logic [1:0] remove_entry(int pos);
      if (entries == 0) return ple_pkg::ST_EMPTY;
      if (pos < 1 || pos > entries) return ple_pkg::ST_RANGE;
      for (int i = pos - 1; i < entries - 1; i++) cells[i] = cells[i+1];
      entries--;
      return ple_pkg::ST_OK;
    endfunction

    // accepted command: update the mirror and queue what it should produce
    function void note_command(ple_pkg::ple_in_t cmd);
      case (cmd.func)
        ple_pkg::FUNC_INS_FRONT: begin
          push_result(insert_value(1, cmd.value), '0, 1'b0, 1'b1);
        end
        ple_pkg::FUNC_INS_POS: begin
          push_result(insert_value(int'(cmd.position), cmd.value), '0, 1'b0, 1'b1);
        end
        ple_pkg::FUNC_INS_END: begin
          push_result(insert_value(entries + 1, cmd.value), '0, 1'b0, 1'b1);
        end
        ple_pkg::FUNC_DEL_FRONT: push_result(remove_entry(1), '0, 1'b0, 1'b1);
        ple_pkg::FUNC_DEL_POS: begin
          push_result(remove_entry(int'(cmd.position)), '0, 1'b0, 1'b1);
        end
        ple_pkg::FUNC_DEL_END: push_result(remove_entry(entries), '0, 1'b0, 1'b1);
        ple_pkg::FUNC_DISPLAY: begin
          if (entries == 0) begin
            push_result(ple_pkg::ST_EMPTY, '0, 1'b0, 1'b1);
          end else begin
            for (int i = 0; i < entries; i++) begin
              push_result(ple_pkg::ST_OK, cells[i], 1'b1, i == entries - 1);
            end
          end
        end
        default: ;
      endcase
    endfunction

    // result transfer: compare against the oldest prediction
    function void check_result(ple_pkg::ple_out_t got);
      ple_pkg::ple_out_t want;
      if (expected_results.size() == 0) begin
        failures++;
        $display("%0t: unexpected result, status %0d element %0d valid %0b last %0b",
                 $time, got.status, got.element, got.element_valid, got.last);
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status) begin
        failures++;
        $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
      end
      if (got.element !== want.element) begin
        failures++;
        $display("%0t: element expected %0d, got %0d", $time, want.element, got.element);
      end
      if (got.element_valid !== want.element_valid) begin
        failures++;
        $display("%0t: element_valid expected %0b, got %0b", $time,
                 want.element_valid, got.element_valid);
      end
      if (got.last !== want.last) begin
        failures++;
        $display("%0t: last expected %0b, got %0b", $time, want.last, got.last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  ple_pkg::ple_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ple_pkg::ple_out_t out_data;

  int send_idle_pct = 13;
  int recv_stall_pct = 66;
  int unsigned cycles = 0;
  bit filling = 1'b1;
  int random_count = 0;
  list_scoreboard tracker = new();

  positional_list_engine dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver with random back-pressure
  always @(posedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  // result transfers go to the scoreboard
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) tracker.check_result(out_data);
  end

  function automatic ple_pkg::ple_in_t build_command(logic [2:0] f,
                                                     logic signed [ple_pkg::DATA_W-1:0] v,
                                                     int p);
    ple_pkg::ple_in_t c;
    c.func = f;
    c.value = v;
    c.position = p[ple_pkg::POS_W-1:0];
    return c;
  endfunction

  // one command transfer; valid stays up if the next command follows at once
  task automatic send_command(input ple_pkg::ple_in_t cmd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (!in_ready);
    tracker.note_command(cmd);
  endtask

  // random commands, biased to fill or drain the list in stretches
  task automatic run_phase(input int send_pct, input int recv_pct);
    int done;
    int roll;
    int n;
    logic grow;
    logic [2:0] f;
    logic signed [ple_pkg::DATA_W-1:0] v;
    int p;
    done = 0;
    send_idle_pct <= send_pct;
    recv_stall_pct <= recv_pct;
    while (done < ITEMS_PER_PHASE) begin
      n = tracker.entries;
      roll = $urandom_range(99);
      grow = (($urandom_range(99) < 70) == filling);
      if (roll < 6) f = ple_pkg::FUNC_DISPLAY;
      else if (roll < 8) f = FUNC_RESERVED;
      else begin
        case ($urandom_range(2))
          0: f = grow ? ple_pkg::FUNC_INS_FRONT : ple_pkg::FUNC_DEL_FRONT;
          1: f = grow ? ple_pkg::FUNC_INS_POS : ple_pkg::FUNC_DEL_POS;
          default: f = grow ? ple_pkg::FUNC_INS_END : ple_pkg::FUNC_DEL_END;
        endcase
      end
      case ($urandom_range(9))
        0: v = 32'sh7fff_ffff;
        1: v = 32'sh8000_0000;
        2: v = '0;
        3: v = '1;
        default: v = $urandom;
      endcase
      // mostly around the valid range, including both boundaries and zero
      p = ($urandom_range(9) < 8) ? $urandom_range(n + 1) : $urandom_range(65);
      send_command(build_command(f, v, p));
      if (f != FUNC_RESERVED) begin
        done++;
        random_count++;
        if (random_count % BIAS_STRETCH == 0) filling = !filling;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty list corner cases
    send_command(build_command(ple_pkg::FUNC_DISPLAY, 0, 0));
    send_command(build_command(ple_pkg::FUNC_DEL_FRONT, 0, 1));
    send_command(build_command(ple_pkg::FUNC_DEL_POS, 0, 65));
    send_command(build_command(ple_pkg::FUNC_DEL_END, 0, 0));
    send_command(build_command(ple_pkg::FUNC_INS_POS, 5, 0));
    send_command(build_command(ple_pkg::FUNC_INS_POS, 6, 2));
    // build a short list with extreme values
    send_command(build_command(ple_pkg::FUNC_INS_FRONT, 32'sh7fff_ffff, 0));
    send_command(build_command(ple_pkg::FUNC_INS_END, 32'sh8000_0000, 64));
    send_command(build_command(ple_pkg::FUNC_INS_POS, 0, 2));
    send_command(build_command(ple_pkg::FUNC_INS_POS, -1, 4));
    send_command(build_command(ple_pkg::FUNC_INS_POS, 7, 64));
    // positions outside the list
    send_command(build_command(ple_pkg::FUNC_DEL_POS, 0, 0));
    send_command(build_command(ple_pkg::FUNC_DEL_POS, 0, 5));
    send_command(build_command(ple_pkg::FUNC_DISPLAY, 0, 127));
    send_command(build_command(FUNC_RESERVED, 32'sh5555_aaaa, 33));
    // deletes from each place
    send_command(build_command(ple_pkg::FUNC_DEL_POS, 0, 2));
    send_command(build_command(ple_pkg::FUNC_DEL_FRONT, 0, 0));
    send_command(build_command(ple_pkg::FUNC_DEL_END, 0, 0));
    send_command(build_command(ple_pkg::FUNC_DISPLAY, 0, 0));

    run_phase(13, 66);
    run_phase(66, 13);
    run_phase(0, 0);
    in_valid <= 1'b0;

    while (tracker.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.failures == 0 && tracker.expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
